### sv/ppd_pkg.sv
package ppd_pkg;

    localparam int IDX_W     = 6;
    localparam int PAL_DEPTH = 1 << IDX_W;
    localparam int WORD_W    = 32;
    localparam int GROUP_W   = 24;
    localparam int SLOT_W    = 2;
    localparam int BYTE_W    = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int DEF_OUT_DEPTH   = 4;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   palette_slot;
        logic [WORD_W-1:0]  palette_word;
        logic [GROUP_W-1:0] packed_group;
        logic [SLOT_W-1:0]  first_slot;
        logic [SLOT_W-1:0]  last_slot;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [SLOT_W-1:0] pixel_slot;
        logic              final_pixel;
    } t_pixel;

    localparam int CMD_W   = $bits(t_cmd);
    localparam int PIXEL_W = $bits(t_pixel);

    // Slot 0 sits in the top six bits of the group.
    function automatic logic [IDX_W-1:0] slot_index(input logic [GROUP_W-1:0] group,
                                                    input logic [SLOT_W-1:0]  slot);
        logic [IDX_W-1:0] idx;
        case (slot)
            2'd0:    idx = group[23:18];
            2'd1:    idx = group[17:12];
            2'd2:    idx = group[11:6];
            default: idx = group[5:0];
        endcase
        return idx;
    endfunction

endpackage

### sv/ppd_fifo.sv
module ppd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/ppd_front.sv
module ppd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  ppd_pkg::t_cmd i_cmd,
    output logic          o_q_push,
    output ppd_pkg::t_cmd o_q_cmd,
    input  logic          i_q_full
);
    import ppd_pkg::*;

    logic r_valid, n_valid;
    t_cmd r_cmd;
    logic accept, keep;

    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    // drop decodes with an empty slot range: they produce nothing
    assign keep     = (i_cmd.op == OP_WRITE) || (i_cmd.last_slot >= i_cmd.first_slot);
    assign n_valid  = (r_valid && i_q_full) || (accept && keep);
    assign o_q_push = r_valid;
    assign o_q_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

### sv/ppd_back.sv
module ppd_back #(
    parameter int OUT_DEPTH = ppd_pkg::DEF_OUT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ppd_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_empty,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_pix_valid,
    output ppd_pkg::t_pixel                o_pix
);
    import ppd_pkg::*;

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [WORD_W-1:0] r_pal [PAL_DEPTH];

    logic              r_active;
    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic              r_pix_valid;
    logic [WORD_W-1:0] r_rd_word;
    logic [SLOT_W-1:0] r_rd_slot;
    logic              r_rd_final;

    logic credit, issue, last_issue, done, load_ok;

    // reserve room for the read still in flight
    assign credit     = ({1'b0, i_out_count} + (CNT_W + 1)'(r_pix_valid))
                        < (CNT_W + 1)'(OUT_DEPTH);
    assign issue      = r_active && (r_cmd.op == OP_DECODE) && credit;
    assign last_issue = issue && (r_slot == r_cmd.last_slot);
    assign done       = (r_active && (r_cmd.op == OP_WRITE)) || last_issue;
    assign load_ok    = !r_active || done;
    assign o_cmd_pop  = load_ok && !i_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pix_valid <= 1'b0;
        end else begin
            r_pix_valid <= issue;
            if (o_cmd_pop) begin
                r_active <= 1'b1;
            end else if (done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_slot <= i_cmd.first_slot;
        end else if (issue) begin
            r_slot <= r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active && (r_cmd.op == OP_WRITE)) begin
            r_pal[r_cmd.palette_slot] <= r_cmd.palette_word;
        end
        if (issue) begin
            r_rd_word  <= r_pal[slot_index(r_cmd.packed_group, r_slot)];
            r_rd_slot  <= r_slot;
            r_rd_final <= (r_slot == r_cmd.last_slot);
        end
    end

    assign o_pix_valid       = r_pix_valid;
    assign o_pix.red         = r_rd_word[23:16];
    assign o_pix.green       = r_rd_word[15:8];
    assign o_pix.blue        = r_rd_word[7:0];
    assign o_pix.alpha       = r_rd_word[31:24];
    assign o_pix.pixel_slot  = r_rd_slot;
    assign o_pix.final_pixel = r_rd_final;

endmodule

### sv/packed_palette_pixel_decoder.sv
// Packed 6-bit palette pixel decoder.
// Input channel (i_push / o_full): one transaction is either a palette write
// (i_operation low: store i_palette_word at entry i_palette_slot) or a decode
// of one 3-byte group holding four 6-bit indices, emitting slots i_first_slot
// up to i_last_slot. A decode with the last slot below the first emits nothing.
// Output channel (o_empty / i_pop): one transaction per pixel, oldest first,
// with red, green, blue, alpha, the source slot and a final flag on the last
// pixel of its group.
// The first pixel of a decode passes the input register, the command queue,
// the sequencer's command register, the palette read register and the output
// queue before it shows on the outputs. The back end reads one palette entry
// per cycle while the output queue has room, through the single read port of
// the palette memory; items are accepted back to back until the command queue fills.
// Reset clears all queues and control state; palette contents stay undefined
// until written. When the receiver stalls, the output queue fills, the back
// end holds its place in the group, the command queue backs up and o_full
// finally rises. Nothing is lost.
module packed_palette_pixel_decoder #(
    parameter int QUEUE_DEPTH = ppd_pkg::DEF_QUEUE_DEPTH,
    parameter int OUT_DEPTH   = ppd_pkg::DEF_OUT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_operation,
    input  logic [ppd_pkg::IDX_W-1:0]        i_palette_slot,
    input  logic [ppd_pkg::WORD_W-1:0]       i_palette_word,
    input  logic [ppd_pkg::GROUP_W-1:0]      i_packed_group,
    input  logic [ppd_pkg::SLOT_W-1:0]       i_first_slot,
    input  logic [ppd_pkg::SLOT_W-1:0]       i_last_slot,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [ppd_pkg::BYTE_W-1:0]       o_red,
    output logic [ppd_pkg::BYTE_W-1:0]       o_green,
    output logic [ppd_pkg::BYTE_W-1:0]       o_blue,
    output logic [ppd_pkg::BYTE_W-1:0]       o_alpha,
    output logic [ppd_pkg::SLOT_W-1:0]       o_pixel_slot,
    output logic                             o_final_pixel
);
    import ppd_pkg::*;

    t_cmd   in_cmd, q_in_cmd, q_out_cmd;
    t_pixel pix, out_pix;
    logic   q_push, q_full, q_empty, q_pop;
    logic   pix_valid, out_full;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
    logic [CMD_W-1:0]   q_out_bits;
    logic [PIXEL_W-1:0] out_bits;

    // gather the input fields into one command
    assign in_cmd.op           = i_operation;
    assign in_cmd.palette_slot = i_palette_slot;
    assign in_cmd.palette_word = i_palette_word;
    assign in_cmd.packed_group = i_packed_group;
    assign in_cmd.first_slot   = i_first_slot;
    assign in_cmd.last_slot    = i_last_slot;

    // front: register and classify, drop decodes that produce nothing
    ppd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_cmd    (in_cmd),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd),
        .i_q_full (q_full)
    );

    // command queue decouples the front from the palette sequencer
    ppd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_bits),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign q_out_cmd = t_cmd'(q_out_bits);

    // back: palette writes and one lookup per cycle while the output queue has room
    ppd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_out_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_out_count (out_count),
        .o_pix_valid (pix_valid),
        .o_pix       (pix)
    );

    // output queue absorbs receiver stalls
    ppd_fifo #(
        .WIDTH (PIXEL_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pix_valid),
        .i_data  (pix),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_bits),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign out_pix       = t_pixel'(out_bits);
    assign o_red         = out_pix.red;
    assign o_green       = out_pix.green;
    assign o_blue        = out_pix.blue;
    assign o_alpha       = out_pix.alpha;
    assign o_pixel_slot  = out_pix.pixel_slot;
    assign o_final_pixel = out_pix.final_pixel;

`ifndef SYNTH
    // the credit check must keep the output queue from overflowing
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_valid |-> !out_full)
        else $error("pixel pushed into a full output queue");

    // empty-range decodes never reach the command queue
    a_no_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && (q_in_cmd.op == OP_DECODE)) |->
        (q_in_cmd.last_slot >= q_in_cmd.first_slot))
        else $error("empty-range decode queued");

    // the sequencer only loads a command that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != '0))
        else $error("command queue popped while empty");
`endif

endmodule

### tb/ppd_pixel_checker.sv
`timescale 1ns / 1ps
module ppd_pixel_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic                        i_operation,
    input  logic [ppd_pkg::IDX_W-1:0]   i_palette_slot,
    input  logic [ppd_pkg::WORD_W-1:0]  i_palette_word,
    input  logic [ppd_pkg::GROUP_W-1:0] i_packed_group,
    input  logic [ppd_pkg::SLOT_W-1:0]  i_first_slot,
    input  logic [ppd_pkg::SLOT_W-1:0]  i_last_slot,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_red,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_green,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_blue,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_alpha,
    input  logic [ppd_pkg::SLOT_W-1:0]  i_pixel_slot,
    input  logic                        i_final_pixel,
    output int                          o_fail_count,
    output int                          o_outstanding
);
    import ppd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [WORD_W-1:0] palette_copy [PAL_DEPTH];
    t_pixel            pending_pixels [$];
    int                fails;

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin
        int                s;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] entry;
        t_pixel            px;
        t_pixel            got;
        t_pixel            want;

        if (i_rst_n) begin
            // Compare the popped pixel first; it was produced by older transactions.
            if (i_pop && !i_empty) begin
                got.red         = i_red;
                got.green       = i_green;
                got.blue        = i_blue;
                got.alpha       = i_alpha;
                got.pixel_slot  = i_pixel_slot;
                got.final_pixel = i_final_pixel;
                if (pending_pixels.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display({"%0t: unexpected pixel r=%02h g=%02h b=%02h a=%02h",
                                  " slot=%0d last=%0b"},
                                 $realtime, got.red, got.green, got.blue, got.alpha,
                                 got.pixel_slot, got.final_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.pixel_slot !== want.pixel_slot ||
                        got.final_pixel !== want.final_pixel) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display({"%0t: pixel mismatch",
                                      " exp r=%02h g=%02h b=%02h a=%02h slot=%0d last=%0b",
                                      " / got r=%02h g=%02h b=%02h a=%02h slot=%0d last=%0b"},
                                     $realtime, want.red, want.green, want.blue, want.alpha,
                                     want.pixel_slot, want.final_pixel, got.red, got.green,
                                     got.blue, got.alpha, got.pixel_slot, got.final_pixel);
                    end
                end
            end

            if (i_push && !i_full) begin
                if (i_operation == OP_WRITE) begin
                    palette_copy[i_palette_slot] = i_palette_word;
                end else if (i_last_slot >= i_first_slot) begin
                    for (s = i_first_slot; s <= i_last_slot; s++) begin
                        idx            = i_packed_group[GROUP_W-1-IDX_W*s -: IDX_W];
                        entry          = palette_copy[idx];
                        px.red         = entry[23:16];
                        px.green       = entry[15:8];
                        px.blue        = entry[7:0];
                        px.alpha       = entry[31:24];
                        px.pixel_slot  = SLOT_W'(s);
                        px.final_pixel = (s == i_last_slot);
                        pending_pixels.push_back(px);
                    end
                end
            end
        end

        o_fail_count  <= fails;
        o_outstanding <= pending_pixels.size();
    end

endmodule

### tb/tb_packed_palette_pixel_decoder.sv
`timescale 1ns / 1ps
module tb_packed_palette_pixel_decoder;
    import ppd_pkg::*;

    localparam int RANDOM_ITEMS    = 250;
    localparam int STALL_LIMIT     = 2000;  // cycles without any transaction
    localparam int HOLD_OFF_AFTER  = 60;    // transactions sent before the long stall
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic               i_operation;
    logic [IDX_W-1:0]   i_palette_slot;
    logic [WORD_W-1:0]  i_palette_word;
    logic [GROUP_W-1:0] i_packed_group;
    logic [SLOT_W-1:0]  i_first_slot;
    logic [SLOT_W-1:0]  i_last_slot;
    logic               o_empty;
    logic               i_pop;
    logic [BYTE_W-1:0]  o_red;
    logic [BYTE_W-1:0]  o_green;
    logic [BYTE_W-1:0]  o_blue;
    logic [BYTE_W-1:0]  o_alpha;
    logic [SLOT_W-1:0]  o_pixel_slot;
    logic               o_final_pixel;

    int                 fail_count;
    int                 outstanding;

    // Stimulus bookkeeping: which palette entries hold a value, so that a
    // decode only ever looks up entries that were written.
    int                 items_sent;
    logic [PAL_DEPTH-1:0] written;
    int                 known_slots [$];
    int                 burst_left;

    packed_palette_pixel_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_operation    (i_operation),
        .i_palette_slot (i_palette_slot),
        .i_palette_word (i_palette_word),
        .i_packed_group (i_packed_group),
        .i_first_slot   (i_first_slot),
        .i_last_slot    (i_last_slot),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_pixel_slot   (o_pixel_slot),
        .o_final_pixel  (o_final_pixel)
    );

    ppd_pixel_checker pixel_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_operation    (i_operation),
        .i_palette_slot (i_palette_slot),
        .i_palette_word (i_palette_word),
        .i_packed_group (i_packed_group),
        .i_first_slot   (i_first_slot),
        .i_last_slot    (i_last_slot),
        .i_empty        (o_empty),
        .i_pop          (i_pop),
        .i_red          (o_red),
        .i_green        (o_green),
        .i_blue         (o_blue),
        .i_alpha        (o_alpha),
        .i_pixel_slot   (o_pixel_slot),
        .i_final_pixel  (o_final_pixel),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offer one transaction from the falling edge and hold it until the
    // block takes it. o_full read right after the rising edge is the value
    // the block saw at that edge.
    task automatic send_item(input logic               op,
                             input logic [IDX_W-1:0]   slot,
                             input logic [WORD_W-1:0]  word,
                             input logic [GROUP_W-1:0] group,
                             input logic [SLOT_W-1:0]  first,
                             input logic [SLOT_W-1:0]  last);
        @(negedge i_clk);
        i_push         = 1'b1;
        i_operation    = op;
        i_palette_slot = slot;
        i_palette_word = word;
        i_packed_group = group;
        i_first_slot   = first;
        i_last_slot    = last;
        do @(posedge i_clk); while (o_full);
        items_sent++;
    endtask

    // Store one palette entry; fill the ignored decode fields with noise.
    task automatic write_entry(input logic [IDX_W-1:0] slot, input logic [WORD_W-1:0] word);
        send_item(OP_WRITE, slot, word, GROUP_W'($urandom()), SLOT_W'($urandom()),
                  SLOT_W'($urandom()));
        if (!written[slot]) begin
            written[slot] = 1'b1;
            known_slots.push_back(int'(slot));
        end
    endtask

    // Decode one group; fill the ignored palette fields with noise.
    task automatic decode_group(input logic [GROUP_W-1:0] group,
                                input logic [SLOT_W-1:0]  first,
                                input logic [SLOT_W-1:0]  last);
        send_item(OP_DECODE, IDX_W'($urandom()), $urandom(), group, first, last);
    endtask

    function automatic logic [IDX_W-1:0] known_index();
        return IDX_W'(known_slots[$urandom_range(0, known_slots.size() - 1)]);
    endfunction

    // Sender: reset, directed transactions, then random traffic, then drain.
    initial begin
        int roll;
        int gap;

        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_operation    = OP_WRITE;
        i_palette_slot = '0;
        i_palette_word = '0;
        i_packed_group = '0;
        i_first_slot   = '0;
        i_last_slot    = '0;
        items_sent     = 0;
        written        = '0;
        burst_left     = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Seed the extreme entries and two alternating bit patterns.
        write_entry(6'd0,  32'h0000_0000);
        write_entry(6'd63, 32'hFFFF_FFFF);
        write_entry(6'd21, 32'h8040_2010);
        write_entry(6'd42, 32'h7F01_FE08);
        // Full groups, all-zero and all-one index fields.
        decode_group({6'd0, 6'd63, 6'd21, 6'd42}, 2'd0, 2'd3);
        decode_group({4{6'd63}}, 2'd0, 2'd3);
        decode_group({4{6'd0}}, 2'd0, 2'd3);
        // Single-slot and partial ranges.
        decode_group({6'd21, 6'd42, 6'd21, 6'd42}, 2'd0, 2'd0);
        decode_group({6'd42, 6'd21, 6'd42, 6'd21}, 2'd3, 2'd3);
        decode_group({6'd63, 6'd0, 6'd42, 6'd21}, 2'd1, 2'd2);
        decode_group({6'd0, 6'd21, 6'd63, 6'd42}, 2'd2, 2'd3);
        decode_group({6'd42, 6'd63, 6'd0, 6'd21}, 2'd0, 2'd1);
        // Empty ranges: last slot below first emits nothing.
        decode_group({6'd63, 6'd63, 6'd0, 6'd0}, 2'd3, 2'd0);
        decode_group({6'd21, 6'd0, 6'd63, 6'd42}, 2'd1, 2'd0);
        decode_group({6'd0, 6'd42, 6'd21, 6'd63}, 2'd3, 2'd2);
        // Overwrite an entry and read it back right behind the write.
        write_entry(6'd0, 32'h1234_5678);
        decode_group({6'd0, 6'd0, 6'd63, 6'd0}, 2'd0, 2'd3);
        write_entry(6'd63, 32'h00FF_00FF);
        decode_group({6'd63, 6'd21, 6'd63, 6'd0}, 2'd1, 2'd3);

        // Random traffic: about a third palette writes to any entry, the rest
        // decodes of known entries with every slot range, empty ones included.
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 30)
                write_entry(IDX_W'($urandom()), $urandom());
            else
                decode_group({known_index(), known_index(), known_index(), known_index()},
                             SLOT_W'($urandom()), SLOT_W'($urandom()));

            // Pick the gap before the next transaction: mostly none or short,
            // now and then long, with occasional back-to-back bursts.
            roll = $urandom_range(0, 99);
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else if (roll < 5) begin
                burst_left = $urandom_range(10, 30);
                gap = 0;
            end else if (roll < 45) begin
                gap = 0;
            end else if (roll < 80) begin
                gap = $urandom_range(1, 2);
            end else if (roll < 96) begin
                gap = $urandom_range(3, 8);
            end else begin
                gap = $urandom_range(20, 40);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_push = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end

        @(negedge i_clk);
        i_push = 1'b0;

        // Drain: wait for every predicted pixel, then give the pipeline time
        // to show anything extra.
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_packed_palette_pixel_decoder: PASS");
        else
            $display("tb_packed_palette_pixel_decoder: FAIL");
        $finish;
    end

    // Receiver: random pop pattern, plus one long hold-off once traffic is
    // under way so the output and command queues fill and o_full rises.
    initial begin
        int  roll;
        int  run;
        bit  held_off;

        i_pop    = 1'b0;
        held_off = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held_off && items_sent >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                i_pop    = 1'b0;
                run      = HOLD_OFF_CYCLES;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 50) begin
                    i_pop = 1'b1;
                    run   = $urandom_range(1, 8);
                end else if (roll < 58) begin
                    i_pop = 1'b1;
                    run   = $urandom_range(20, 40);
                end else if (roll < 88) begin
                    i_pop = 1'b0;
                    run   = $urandom_range(1, 3);
                end else if (roll < 97) begin
                    i_pop = 1'b0;
                    run   = $urandom_range(4, 12);
                end else begin
                    i_pop = 1'b0;
                    run   = $urandom_range(20, 50);
                end
            end
            repeat (run) @(negedge i_clk);
        end
    end

    // Watchdog: end the run when no transaction moves on either side for
    // too long.
    initial begin
        int idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_packed_palette_pixel_decoder: FAIL");
        $finish;
    end

endmodule
